FILE: sv/stt_pkg.sv
// Shared types and constants for the spin tachometer tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned MODE_COUNT_DEF = 8;
  localparam int unsigned TIME_BITS_DEF  = 32;

  localparam int unsigned STAMP_W = 32;   // now_ms field width
  localparam int unsigned VAL_W   = 16;   // period, rpm, counts, registers
  localparam int unsigned DIV_STEPS_W = $clog2(VAL_W);
  localparam int unsigned OUT_W   = 104;  // result fields padded to whole bytes

  localparam logic [VAL_W-1:0] RPM_NUM     = 16'd60000;
  localparam logic [VAL_W-1:0] TIMEOUT_RST = 16'd1024;
  localparam logic [VAL_W-1:0] VAL_MAX     = 16'hffff;
  localparam logic [7:0]       LEDS_OFF    = 8'hff;

  typedef enum logic [1:0] {
    REQ_TIME   = 2'd0,
    REQ_PULSE  = 2'd1,
    REQ_BUTTON = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_STILL = 2'd0,
    PH_FIRST = 2'd1,
    PH_RUN   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT    = 2'd0,
    REG_BEST_SPEED = 2'd1,
    REG_BEST_LOOPS = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_PUSH = 2'd2
  } fsm_e;

  // Result word, highest bits first; run_state sits at bit 0.
  typedef struct packed {
    logic [4:0]       pad;
    logic [3:0]       random_pick;
    logic [7:0]       led_pattern;
    logic             led_write;
    logic             save_request;
    logic [VAL_W-1:0] best_loop_count;
    logic [VAL_W-1:0] best_speed_rpm;
    logic [VAL_W-1:0] loop_count;
    logic [VAL_W-1:0] speed_rpm;
    logic [VAL_W-1:0] loop_time_ms;
    logic [2:0]       mode;
    logic [1:0]       run_state;
  } result_t;

  // Active-low mode indicator; modes 8 and up light nothing.
  function automatic logic [7:0] mode_leds(input logic [3:0] m);
    logic [7:0] pat;
    pat = LEDS_OFF;
    if (!m[3]) pat[m[2:0]] = 1'b0;
    return pat;
  endfunction

endpackage

FILE: sv/stt_div.sv
// Bit-serial restoring divider: RPM_NUM / divisor, one quotient bit per cycle.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [stt_pkg::VAL_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [stt_pkg::VAL_W-1:0] quot_o
);
  import stt_pkg::*;

  logic                   busy_q, busy_d;
  logic [DIV_STEPS_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0]       rem_q, rem_d;
  logic [VAL_W-1:0]       dvd_q, dvd_d;   // dividend out at top, quotient in at bottom
  logic [VAL_W-1:0]       dsr_q, dsr_d;
  logic [VAL_W:0]         trial;
  logic                   fits;

  assign trial = {rem_q, dvd_q[VAL_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = RPM_NUM;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
      dvd_d = {dvd_q[VAL_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_STEPS_W'(VAL_W - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

FILE: sv/spin_tachometer_tracker.sv
// An accepted item goes from idle to the push state, which writes the
//   output register once it is free; a pulse while running first passes the
//   divide state and the 16-step serial rpm divider. Items are only taken in idle.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_ni, async, active low): tracker still, mode 0, records and
//   timestamps 0, timeout 1024 ms, no result pending.
`timescale 1ns / 1ps

module spin_tachometer_tracker #(
  parameter int unsigned MODE_COUNT = stt_pkg::MODE_COUNT_DEF,  // 2..16
  parameter int unsigned TIME_BITS  = stt_pkg::TIME_BITS_DEF    // 16..32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_addr_i,
  input  logic [stt_pkg::VAL_W-1:0]   cfg_wdata_i,
  // event stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [stt_pkg::STAMP_W-1:0] s_axis_tdata,   // now_ms[31:0]
  input  logic [1:0]                  s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // run_state[1:0], mode[4:2], loop_time_ms[20:5], speed_rpm[36:21],
  // loop_count[52:37], best_speed_rpm[68:53], best_loop_count[84:69],
  // save_request[85], led_write[86], led_pattern[94:87], random_pick[98:95],
  // zero pad[103:99]
  output logic [stt_pkg::OUT_W-1:0]   m_axis_tdata
);
  import stt_pkg::*;

  localparam int unsigned MODE_W = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;

  fsm_e                 state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [TIME_BITS-1:0] last_q, last_d;
  logic [VAL_W-1:0]     period_q, period_d;
  logic [VAL_W-1:0]     rot_q, rot_d;
  logic [VAL_W-1:0]     rpm_q, rpm_d;
  logic [VAL_W-1:0]     best_spd_q, best_spd_d;
  logic [VAL_W-1:0]     best_lps_q, best_lps_d;
  logic [VAL_W-1:0]     timeout_q, timeout_d;
  logic [3:0]           pick_q, pick_d;

  // per-item flags held until the result is pushed
  logic                 save_q, save_d;
  logic                 lw_q, lw_d;
  logic [7:0]           pat_q, pat_d;

  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;

  logic                 in_xfer, out_free;
  logic [TIME_BITS-1:0] now, gap;
  logic [STAMP_W-1:0]   gap_w;
  logic [VAL_W-1:0]     per;
  logic [MODE_W-1:0]    mode_nxt;
  logic                 div_start, div_busy;
  logic [VAL_W-1:0]     div_quot;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Gap since last pulse, wrapping at the timestamp width; period saturates.
  assign now   = s_axis_tdata[TIME_BITS-1:0];
  assign gap   = now - last_q;
  assign gap_w = STAMP_W'(gap);
  assign per   = (|gap_w[STAMP_W-1:VAL_W]) ? VAL_MAX : gap_w[VAL_W-1:0];

  assign mode_nxt = (mode_q == MODE_W'(MODE_COUNT - 1)) ? '0 : mode_q + 1'b1;

  stt_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i ((per == '0) ? VAL_W'(1) : per),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    mode_d     = mode_q;
    last_d     = last_q;
    period_d   = period_q;
    rot_d      = rot_q;
    rpm_d      = rpm_q;
    best_spd_d = best_spd_q;
    best_lps_d = best_lps_q;
    timeout_d  = timeout_q;
    pick_d     = pick_q;
    save_d     = save_q;
    lw_d       = lw_q;
    pat_d      = pat_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    div_start  = 1'b0;

    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;

    // Config must arrive only in idle; unchecked, it can meet an event update.
    if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_TIMEOUT:    timeout_d  = cfg_wdata_i;
        REG_BEST_SPEED: best_spd_d = cfg_wdata_i;
        REG_BEST_LOOPS: best_lps_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          save_d  = 1'b0;
          lw_d    = 1'b0;
          pat_d   = '0;
          state_d = ST_PUSH;
          case (req_e'(s_axis_tuser))
            REQ_TIME: begin
              if (phase_q != PH_STILL && gap_w > STAMP_W'(timeout_q)) begin
                phase_d = PH_STILL;
                lw_d    = 1'b1;
                pat_d   = mode_leds(4'(mode_q));
                if (rpm_q > best_spd_q || rot_q > best_lps_q) begin
                  best_spd_d = rpm_q;
                  best_lps_d = rot_q;
                  save_d     = 1'b1;
                end
              end
            end
            REQ_BUTTON: begin
              if (phase_q == PH_STILL) begin
                mode_d = mode_nxt;
                lw_d   = 1'b1;
                pat_d  = mode_leds(4'(mode_nxt));
              end
            end
            REQ_PULSE: begin
              last_d = now;
              case (phase_q)
                PH_STILL: begin
                  lw_d    = 1'b1;
                  pat_d   = LEDS_OFF;
                  phase_d = PH_FIRST;
                end
                PH_FIRST: begin
                  phase_d  = PH_RUN;
                  period_d = per;
                  rot_d    = VAL_W'(1);
                  pick_d   = s_axis_tdata[3:0];
                end
                default: begin
                  period_d  = per;
                  if (rot_q != VAL_MAX) rot_d = rot_q + 1'b1;
                  div_start = 1'b1;
                  state_d   = ST_DIV;
                end
              endcase
            end
            default: ;  // unused request code: report state unchanged
          endcase
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          rpm_d   = div_quot;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_d.pad             = '0;
          out_d.random_pick     = pick_q;
          out_d.led_pattern     = pat_q;
          out_d.led_write       = lw_q;
          out_d.save_request    = save_q;
          out_d.best_loop_count = best_lps_q;
          out_d.best_speed_rpm  = best_spd_q;
          out_d.loop_count      = rot_q;
          out_d.speed_rpm       = rpm_q;
          out_d.loop_time_ms    = period_q;
          out_d.mode            = 3'(mode_q);
          out_d.run_state       = phase_q;
          out_vld_d             = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_STILL;
      mode_q     <= '0;
      last_q     <= '0;
      period_q   <= '0;
      rot_q      <= '0;
      rpm_q      <= '0;
      best_spd_q <= '0;
      best_lps_q <= '0;
      timeout_q  <= TIMEOUT_RST;
      pick_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      last_q     <= last_d;
      period_q   <= period_d;
      rot_q      <= rot_d;
      rpm_q      <= rpm_d;
      best_spd_q <= best_spd_d;
      best_lps_q <= best_lps_d;
      timeout_q  <= timeout_d;
      pick_q     <= pick_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    save_q <= save_d;
    lw_q   <= lw_d;
    pat_q  <= pat_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: sv/stt_checker.sv
// Port-level checks for spin_tachometer_tracker, bound to the top level.
// Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [stt_pkg::OUT_W-1:0]   m_axis_tdata
);
  import stt_pkg::*;

  result_t res;
  assign res = m_axis_tdata;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_led_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.led_write |-> res.led_pattern == '0)
    else $error("led pattern without led write");

  a_save_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.save_request |-> res.run_state == PH_STILL && res.led_write)
    else $error("save request outside a spin end");

  a_rpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.speed_rpm <= RPM_NUM)
    else $error("rpm above limit");

endmodule

bind spin_tachometer_tracker stt_checker u_stt_checker (.*);

FILE: sim/tb_top.sv
// Self-checking bench for spin_tachometer_tracker: drives timestamped events,
// predicts every reading with its own tracker state and compares field by field.
// Depends on stt_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module tb_top;
  import stt_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;     // undefined request code
  localparam int unsigned LIMIT_CYCLES = 800000;   // watchdog, far above a slow run
  localparam int unsigned SETTLE_CYC   = 24;       // above the divider latency
  localparam int unsigned MAX_PRINTS   = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_addr_i;
  logic [VAL_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [STAMP_W-1:0] s_axis_tdata;   // now_ms[31:0]
  logic [1:0]         s_axis_tuser;   // req_type[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // run_state, mode, loop_time_ms, speed_rpm, loop_count, best_speed_rpm,
  // best_loop_count, save_request, led_write, led_pattern, random_pick, pad
  logic [OUT_W-1:0]   m_axis_tdata;

  spin_tachometer_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bench copy of the tracker state plus the registers that steer it.
  typedef struct {
    phase_e           phase;
    logic [2:0]       mode;
    logic [31:0]      last_pulse;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] rotations;
    logic [VAL_W-1:0] rpm;
    logic [VAL_W-1:0] best_speed;
    logic [VAL_W-1:0] best_loops;
    logic [3:0]       pick;
    logic [VAL_W-1:0] timeout;
  } tach_t;

  tach_t       tach;
  result_t     expected_readings[$];
  logic [31:0] ms_now;            // running event timestamp, wraps freely
  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned events_sent;
  int unsigned readings_seen;
  int unsigned error_count;
  int unsigned cycle_count;

  function automatic void reset_tracker();
    tach.phase      = PH_STILL;
    tach.mode       = '0;
    tach.last_pulse = '0;
    tach.period     = '0;
    tach.rotations  = '0;
    tach.rpm        = '0;
    tach.best_speed = '0;
    tach.best_loops = '0;
    tach.pick       = '0;
    tach.timeout    = TIMEOUT_RST;
  endfunction

  // Advances the bench tracker by one event and returns the reading it owes.
  function automatic result_t track_event(input logic [1:0] req, input logic [31:0] stamp);
    result_t          r;
    logic [31:0]      gap;
    logic [VAL_W-1:0] per;
    r   = '0;
    gap = stamp - tach.last_pulse;                  // modulo 2^32
    per = (gap > 32'h0000_ffff) ? VAL_MAX : gap[VAL_W-1:0];
    case (req)
      REQ_TIME: begin
        // only a strictly longer gap ends the spin
        if (tach.phase != PH_STILL && gap > {16'h0, tach.timeout}) begin
          tach.phase    = PH_STILL;
          r.led_write   = 1'b1;
          r.led_pattern = ~(8'd1 << tach.mode);
          // either record beaten: both take the spin values, one may drop
          if (tach.rpm > tach.best_speed || tach.rotations > tach.best_loops) begin
            tach.best_speed = tach.rpm;
            tach.best_loops = tach.rotations;
            r.save_request  = 1'b1;
          end
        end
      end
      REQ_BUTTON: begin
        if (tach.phase == PH_STILL) begin
          tach.mode = (tach.mode == 3'(MODE_COUNT_DEF - 1)) ? 3'd0 : tach.mode + 3'd1;
          r.led_write   = 1'b1;
          r.led_pattern = ~(8'd1 << tach.mode);
        end
      end
      REQ_PULSE: begin
        case (tach.phase)
          PH_STILL: begin
            r.led_write     = 1'b1;
            r.led_pattern   = LEDS_OFF;
            tach.phase      = PH_FIRST;
            tach.last_pulse = stamp;
          end
          PH_FIRST: begin
            // first full turn: period known, rpm left as it was
            tach.phase      = PH_RUN;
            tach.period     = per;
            tach.last_pulse = stamp;
            tach.rotations  = 16'd1;
            tach.pick       = stamp[3:0];
          end
          default: begin
            tach.period     = per;
            tach.last_pulse = stamp;
            if (tach.rotations != VAL_MAX) tach.rotations = tach.rotations + 16'd1;
            tach.rpm = 16'({16'h0, RPM_NUM} / ((per == '0) ? 32'd1 : {16'h0, per}));
          end
        endcase
      end
      default: ;  // unused code: state reported unchanged
    endcase
    r.run_state       = tach.phase;
    r.mode            = tach.mode;
    r.loop_time_ms    = tach.period;
    r.speed_rpm       = tach.rpm;
    r.loop_count      = tach.rotations;
    r.best_speed_rpm  = tach.best_speed;
    r.best_loop_count = tach.best_loops;
    r.random_pick     = tach.pick;
    return r;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] reading %0d: %s", $time, readings_seen, what);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      flag_error($sformatf("%s expected 0x%0h got 0x%0h", fname, want, got));
  endtask

  // Result side: every transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin : check_readings
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      readings_seen++;
      if (expected_readings.size() == 0) begin
        flag_error("reading with nothing outstanding");
      end else begin
        want = expected_readings.pop_front();
        check_field("run_state",       want.run_state,       got.run_state);
        check_field("mode",            want.mode,            got.mode);
        check_field("loop_time_ms",    want.loop_time_ms,    got.loop_time_ms);
        check_field("speed_rpm",       want.speed_rpm,       got.speed_rpm);
        check_field("loop_count",      want.loop_count,      got.loop_count);
        check_field("best_speed_rpm",  want.best_speed_rpm,  got.best_speed_rpm);
        check_field("best_loop_count", want.best_loop_count, got.best_loop_count);
        check_field("save_request",    want.save_request,    got.save_request);
        check_field("led_write",       want.led_write,       got.led_write);
        check_field("led_pattern",     want.led_pattern,     got.led_pattern);
        check_field("random_pick",     want.random_pick,     got.random_pick);
        check_field("pad",             want.pad,             got.pad);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts while enabled.
  initial begin : sink_pacing
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // One event transfer; the prediction is queued before it is offered.
  // tvalid stays high between back-to-back events.
  task automatic send_event(input logic [1:0] req, input logic [31:0] stamp);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    expected_readings.push_back(track_event(req, stamp));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= req;
    events_sent++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending, let every outstanding reading come back, then settle.
  task automatic drain_readings();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Register write; only called with the tracker idle.
  task automatic load_register(input reg_e idx, input logic [VAL_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_TIMEOUT:    tach.timeout    = val;
      REG_BEST_SPEED: tach.best_speed = val;
      REG_BEST_LOOPS: tach.best_loops = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Gap to the next pulse: mostly plausible spin rates, some zero,
  // saturating and wildly wrapped gaps.
  function automatic logic [31:0] pulse_gap();
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return $urandom_range(65535, 200000);
      2:       return $urandom();
      3, 4:    return $urandom_range(0, 65535);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  // A well-formed spin: buttons while still, start pulse, run of pulses with
  // harmless events mixed in, then usually a time check past the timeout.
  task automatic random_spin();
    int unsigned n_pulses;
    int unsigned k;
    logic [31:0] extra;
    repeat ($urandom_range(0, 3)) begin
      ms_now += $urandom_range(0, 500);
      send_event(REQ_BUTTON, ms_now);
    end
    ms_now += $urandom_range(1, 5000);
    send_event(REQ_PULSE, ms_now);
    n_pulses = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
    for (k = 0; k < n_pulses; k++) begin
      ms_now = tach.last_pulse + pulse_gap();
      send_event(REQ_PULSE, ms_now);
      case ($urandom_range(0, 11))
        0: send_event(REQ_TIME, tach.last_pulse + $urandom_range(0, tach.timeout));
        1: send_event(REQ_BUTTON, tach.last_pulse + $urandom_range(0, 100));
        2: send_event(REQ_UNUSED, $urandom());
        default: ;
      endcase
    end
    // occasionally leave the spin running into the next one
    if ($urandom_range(0, 9) != 0) begin
      extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : 32'd0;
      ms_now = tach.last_pulse + {16'h0, tach.timeout} + 32'd1 + extra;
      send_event(REQ_TIME, ms_now);
    end
  endtask

  // Random phase under one register setting; pauses once halfway until all
  // readings are back.
  task automatic run_random_phase(input logic [VAL_W-1:0] tmo, input logic [VAL_W-1:0] bspd,
                                  input logic [VAL_W-1:0] bloops, input bit src_idle,
                                  input bit sink_idle, input int unsigned n_items);
    int unsigned stop_at;
    int unsigned half;
    bit          paused;
    drain_readings();
    load_register(REG_TIMEOUT, tmo);
    load_register(REG_BEST_SPEED, bspd);
    load_register(REG_BEST_LOOPS, bloops);
    src_idle_en  = src_idle;
    sink_idle_en = sink_idle;
    stop_at = events_sent + n_items;
    half    = events_sent + n_items / 2;
    paused  = 1'b0;
    ms_now  = $urandom();
    while (events_sent < stop_at) begin
      if (!paused && events_sent >= half) begin
        drain_readings();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any timestamp
        repeat ($urandom_range(1, 4)) send_event(2'($urandom_range(0, 3)), $urandom());
      end else begin
        random_spin();
      end
    end
  endtask

  // Still tracker: time check and unused code do nothing, buttons cycle the
  // mode through its wrap.
  task automatic test_still_events();
    send_event(REQ_TIME, 32'd100);
    send_event(REQ_UNUSED, 32'hffff_ffff);
    repeat (MODE_COUNT_DEF) send_event(REQ_BUTTON, 32'd200);
  endtask

  // One spin across the timestamp wrap with zero, saturating and unit
  // periods, then the timeout boundary at exactly and just past the limit.
  task automatic test_spin_edges();
    ms_now = 32'hffff_fff0;
    send_event(REQ_PULSE, ms_now);            // start, LEDs off
    send_event(REQ_BUTTON, ms_now);           // ignored while spinning
    send_event(REQ_PULSE, ms_now);            // first turn, zero period
    ms_now += 32'd20;                         // crosses the wrap
    send_event(REQ_PULSE, ms_now);
    send_event(REQ_PULSE, ms_now);            // zero period, top rpm
    send_event(REQ_UNUSED, 32'd0);
    ms_now += 32'd70000;                      // period saturates
    send_event(REQ_PULSE, ms_now);
    ms_now += 32'd65535;
    send_event(REQ_PULSE, ms_now);
    ms_now += 32'd1;
    send_event(REQ_PULSE, ms_now);
    send_event(REQ_TIME, ms_now + {16'h0, tach.timeout});           // not yet
    send_event(REQ_TIME, ms_now + {16'h0, tach.timeout} + 32'd1);   // ends, saves
  endtask

  task automatic test_default_timeout();
    run_random_phase(TIMEOUT_RST, 16'd0, 16'd0, 1'b1, 1'b1, 250);
  endtask

  // records at the top: never beaten, no save requests
  task automatic test_shortest_timeout();
    run_random_phase(16'd1, VAL_MAX, VAL_MAX, 1'b1, 1'b1, 200);
  endtask

  task automatic test_longest_timeout();
    run_random_phase(VAL_MAX, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'b1, 1'b0, 200);
  endtask

  // zero timeout ends a spin on any nonzero gap
  task automatic test_zero_timeout();
    run_random_phase(16'd0, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 200)), 1'b0, 1'b1, 150);
  endtask

  // high speed record, low loop record: updates that drop the speed
  task automatic test_record_swap();
    run_random_phase(16'($urandom_range(20, 3000)), 16'd30000, 16'd5, 1'b1, 1'b1, 250);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    run_random_phase(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 40)), 1'b0, 1'b0, 350);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_TIMEOUT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TIME;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    ms_now        = '0;
    reset_tracker();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_still_events();
    test_spin_edges();
    test_default_timeout();
    test_shortest_timeout();
    test_longest_timeout();
    test_zero_timeout();
    test_record_swap();
    test_full_rate();
    drain_readings();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/stt_pkg.sv
sv/stt_div.sv
sv/spin_tachometer_tracker.sv
sv/stt_checker.sv
sim/tb_top.sv
